@@ rtl/eqvt_pkg.sv @@
// Shared types and constants for the Euler-to-quaternion vertex transform core.
// Used by eqvt_rot_setup and euler_quat_vertex_transform_core; no dependencies.
package eqvt_pkg;

   localparam int QUAT_BITS   = 16;
   localparam int QUAT_FRAC   = QUAT_BITS - 2;
   localparam int MAT_FRAC    = QUAT_FRAC + 8;
   localparam int MAT_SHIFT   = 2 * QUAT_FRAC - MAT_FRAC;
   localparam int QPROD_W     = 2 * QUAT_BITS;
   localparam int MSUM_W      = QPROD_W + 3;
   localparam int MAT_W       = MSUM_W - MAT_SHIFT;

   localparam int ANGLE_W     = 16;
   localparam int SCALE_W     = 16;
   localparam int OFFSET_W    = 32;
   localparam int VERTEX_W    = 24;
   localparam int WORLD_W     = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_IDX_W = 5;
   localparam int CORDIC_W     = 34;
   localparam int CORDIC_GAIN  = 652032874;
   localparam int TRIG_W       = 32;
   localparam int TRIG_FRAC    = 30;
   localparam int TPROD_W      = 2 * TRIG_W;
   localparam int QSUM_W       = TPROD_W + 1;
   localparam int QRND_SHIFT   = 2 * TRIG_FRAC - QUAT_FRAC;

   localparam int VPROD_W     = MAT_W + VERTEX_W;
   localparam int VSUM_W      = VPROD_W + 2;
   localparam int VRND_SHIFT  = MAT_FRAC - 8;
   localparam int T_W         = VSUM_W - VRND_SHIFT;
   localparam int SPROD_W     = T_W + SCALE_W + 1;
   localparam int SRND_SHIFT  = 16;
   localparam int SRND_W      = SPROD_W - SRND_SHIFT;
   localparam int WSUM_W      = SRND_W + 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PITCH    = 3'd0,
      CSR_YAW      = 3'd1,
      CSR_ROLL     = 3'd2,
      CSR_SCALE    = 3'd3,
      CSR_OFFSET_X = 3'd4,
      CSR_OFFSET_Y = 3'd5,
      CSR_OFFSET_Z = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [VERTEX_W-1:0] vertex_x;
      logic signed [VERTEX_W-1:0] vertex_y;
      logic signed [VERTEX_W-1:0] vertex_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [WORLD_W-1:0] world_x;
      logic signed [WORLD_W-1:0] world_y;
      logic signed [WORLD_W-1:0] world_z;
      logic                      clipped;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] pitch;
      logic signed [ANGLE_W-1:0] yaw;
      logic signed [ANGLE_W-1:0] roll;
   } angle_type;

   typedef logic [8:0][MAT_W-1:0] mat_type;

endpackage

@@ rtl/eqvt_rot_setup.sv @@
// Rotation setup: three-lane iterative CORDIC, quaternion build and matrix build.
// Depends on eqvt_pkg.
module eqvt_rot_setup (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  eqvt_pkg::angle_type angles,
   output logic                busy,
   output eqvt_pkg::mat_type   matrix
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CORDIC = 7'b0000010,
      ST_QMUL_A = 7'b0000100,
      ST_QMUL_B = 7'b0001000,
      ST_QSUM   = 7'b0010000,
      ST_MMUL   = 7'b0100000,
      ST_MSUM   = 7'b1000000
   } state_type;

   localparam logic [eqvt_pkg::CORDIC_IDX_W-1:0] LAST_STEP =
      eqvt_pkg::CORDIC_IDX_W'(eqvt_pkg::CORDIC_STEPS - 1);

   function automatic logic signed [eqvt_pkg::CORDIC_W-1:0] atan_step(
      input logic [eqvt_pkg::CORDIC_IDX_W-1:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return $signed(eqvt_pkg::CORDIC_W'(v));
   endfunction

   function automatic logic signed [eqvt_pkg::TRIG_W-1:0] mul_rnd(
      input logic signed [eqvt_pkg::TRIG_W-1:0] a,
      input logic signed [eqvt_pkg::TRIG_W-1:0] b);
      logic signed [eqvt_pkg::TPROD_W-1:0] p;
      logic        [eqvt_pkg::TPROD_W-1:0] r;
      p = a * b;
      r = p + (eqvt_pkg::TPROD_W'(1) << (eqvt_pkg::TRIG_FRAC - 1));
      return $signed(r[eqvt_pkg::TRIG_FRAC+eqvt_pkg::TRIG_W-1:eqvt_pkg::TRIG_FRAC]);
   endfunction

   function automatic logic signed [eqvt_pkg::QUAT_BITS-1:0] qsat(
      input logic [eqvt_pkg::QSUM_W-1:0] v);
      logic [eqvt_pkg::QSUM_W-1:0]                          r;
      logic [eqvt_pkg::QSUM_W-eqvt_pkg::QRND_SHIFT-1:0]     s;
      logic [eqvt_pkg::QSUM_W-eqvt_pkg::QRND_SHIFT-eqvt_pkg::QUAT_BITS:0] top;
      r   = v + (eqvt_pkg::QSUM_W'(1) << (eqvt_pkg::QRND_SHIFT - 1));
      s   = r[eqvt_pkg::QSUM_W-1:eqvt_pkg::QRND_SHIFT];
      top = s[eqvt_pkg::QSUM_W-eqvt_pkg::QRND_SHIFT-1:eqvt_pkg::QUAT_BITS-1];
      if ((top == '0) || (top == '1)) begin
         return $signed(s[eqvt_pkg::QUAT_BITS-1:0]);
      end else if (s[eqvt_pkg::QSUM_W-eqvt_pkg::QRND_SHIFT-1]) begin
         return $signed({1'b1, {(eqvt_pkg::QUAT_BITS-1){1'b0}}});
      end else begin
         return $signed({1'b0, {(eqvt_pkg::QUAT_BITS-1){1'b1}}});
      end
   endfunction

   function automatic logic [eqvt_pkg::MAT_W-1:0] mrnd(
      input logic [eqvt_pkg::MSUM_W-1:0] v);
      logic [eqvt_pkg::MSUM_W-1:0] r;
      r = v + (eqvt_pkg::MSUM_W'(1) << (eqvt_pkg::MAT_SHIFT - 1));
      return r[eqvt_pkg::MSUM_W-1:eqvt_pkg::MAT_SHIFT];
   endfunction

   function automatic logic signed [eqvt_pkg::MSUM_W-1:0] mx(
      input logic signed [eqvt_pkg::QPROD_W-1:0] v);
      return eqvt_pkg::MSUM_W'(v);
   endfunction

   state_type state_ff, state_in;
   logic [eqvt_pkg::CORDIC_IDX_W-1:0] iter_ff, iter_in;

   logic signed [eqvt_pkg::CORDIC_W-1:0] cx_ff [3];
   logic signed [eqvt_pkg::CORDIC_W-1:0] cy_ff [3];
   logic signed [eqvt_pkg::CORDIC_W-1:0] cz_ff [3];
   logic signed [eqvt_pkg::CORDIC_W-1:0] cx_in [3];
   logic signed [eqvt_pkg::CORDIC_W-1:0] cy_in [3];
   logic signed [eqvt_pkg::CORDIC_W-1:0] cz_in [3];
   logic        [eqvt_pkg::ANGLE_W-1:0]  lane_angle [3];

   logic signed [eqvt_pkg::TRIG_W-1:0] a_ff [4];
   logic signed [eqvt_pkg::TRIG_W-1:0] a_in [4];
   logic signed [eqvt_pkg::TPROD_W-1:0] b_ff [8];
   logic signed [eqvt_pkg::TPROD_W-1:0] b_in [8];

   logic signed [eqvt_pkg::QUAT_BITS-1:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [eqvt_pkg::QUAT_BITS-1:0] qw_in, qx_in, qy_in, qz_in;

   logic signed [eqvt_pkg::QPROD_W-1:0] m_ff [10];
   logic signed [eqvt_pkg::QPROD_W-1:0] m_in [10];

   eqvt_pkg::mat_type mat_ff, mat_in;

   logic signed [eqvt_pkg::TRIG_W-1:0] cp, sp, cyw, syw, cr, sr;

   assign lane_angle[0] = angles.pitch;
   assign lane_angle[1] = angles.yaw;
   assign lane_angle[2] = angles.roll;

   assign cp  = cx_ff[0][eqvt_pkg::TRIG_W-1:0];
   assign sp  = cy_ff[0][eqvt_pkg::TRIG_W-1:0];
   assign cyw = cx_ff[1][eqvt_pkg::TRIG_W-1:0];
   assign syw = cy_ff[1][eqvt_pkg::TRIG_W-1:0];
   assign cr  = cx_ff[2][eqvt_pkg::TRIG_W-1:0];
   assign sr  = cy_ff[2][eqvt_pkg::TRIG_W-1:0];

   always_comb begin
      logic signed [eqvt_pkg::CORDIC_W-1:0] dx;
      logic signed [eqvt_pkg::CORDIC_W-1:0] dy;
      logic signed [eqvt_pkg::CORDIC_W-1:0] at;
      at = atan_step(iter_ff);
      for (int l = 0; l < 3; l++) begin
         dx = cy_ff[l] >>> iter_ff;
         dy = cx_ff[l] >>> iter_ff;
         if ((state_ff == ST_IDLE) || start) begin
            cx_in[l] = eqvt_pkg::CORDIC_W'(eqvt_pkg::CORDIC_GAIN);
            cy_in[l] = '0;
            cz_in[l] = $signed({{(eqvt_pkg::CORDIC_W-eqvt_pkg::ANGLE_W-15)
                                 {lane_angle[l][eqvt_pkg::ANGLE_W-1]}},
                                lane_angle[l], 15'b0});
         end else if (state_ff != ST_CORDIC) begin
            cx_in[l] = cx_ff[l];
            cy_in[l] = cy_ff[l];
            cz_in[l] = cz_ff[l];
         end else if (!cz_ff[l][eqvt_pkg::CORDIC_W-1]) begin
            cx_in[l] = cx_ff[l] - dx;
            cy_in[l] = cy_ff[l] + dy;
            cz_in[l] = cz_ff[l] - at;
         end else begin
            cx_in[l] = cx_ff[l] + dx;
            cy_in[l] = cy_ff[l] - dy;
            cz_in[l] = cz_ff[l] + at;
         end
      end
   end

   always_comb begin
      a_in[0] = mul_rnd(cr, sp);
      a_in[1] = mul_rnd(sr, cp);
      a_in[2] = mul_rnd(cr, cp);
      a_in[3] = mul_rnd(sr, sp);
      b_in[0] = a_ff[0] * syw;
      b_in[1] = a_ff[1] * cyw;
      b_in[2] = a_ff[0] * cyw;
      b_in[3] = a_ff[1] * syw;
      b_in[4] = a_ff[2] * syw;
      b_in[5] = a_ff[3] * cyw;
      b_in[6] = a_ff[2] * cyw;
      b_in[7] = a_ff[3] * syw;
      qx_in = qsat(eqvt_pkg::QSUM_W'(b_ff[0]) - eqvt_pkg::QSUM_W'(b_ff[1]));
      qy_in = qsat(-eqvt_pkg::QSUM_W'(b_ff[2]) - eqvt_pkg::QSUM_W'(b_ff[3]));
      qz_in = qsat(eqvt_pkg::QSUM_W'(b_ff[4]) - eqvt_pkg::QSUM_W'(b_ff[5]));
      qw_in = qsat(eqvt_pkg::QSUM_W'(b_ff[6]) + eqvt_pkg::QSUM_W'(b_ff[7]));
   end

   always_comb begin
      m_in[0] = qw_ff * qw_ff;
      m_in[1] = qx_ff * qx_ff;
      m_in[2] = qy_ff * qy_ff;
      m_in[3] = qz_ff * qz_ff;
      m_in[4] = qx_ff * qy_ff;
      m_in[5] = qw_ff * qz_ff;
      m_in[6] = qx_ff * qz_ff;
      m_in[7] = qw_ff * qy_ff;
      m_in[8] = qy_ff * qz_ff;
      m_in[9] = qw_ff * qx_ff;
      mat_in[0] = mrnd(mx(m_ff[0]) + mx(m_ff[1]) - mx(m_ff[2]) - mx(m_ff[3]));
      mat_in[1] = mrnd((mx(m_ff[4]) - mx(m_ff[5])) <<< 1);
      mat_in[2] = mrnd((mx(m_ff[6]) + mx(m_ff[7])) <<< 1);
      mat_in[3] = mrnd((mx(m_ff[4]) + mx(m_ff[5])) <<< 1);
      mat_in[4] = mrnd(mx(m_ff[0]) - mx(m_ff[1]) + mx(m_ff[2]) - mx(m_ff[3]));
      mat_in[5] = mrnd((mx(m_ff[8]) - mx(m_ff[9])) <<< 1);
      mat_in[6] = mrnd((mx(m_ff[6]) - mx(m_ff[7])) <<< 1);
      mat_in[7] = mrnd((mx(m_ff[8]) + mx(m_ff[9])) <<< 1);
      mat_in[8] = mrnd(mx(m_ff[0]) - mx(m_ff[1]) - mx(m_ff[2]) + mx(m_ff[3]));
   end

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      if (start) begin
         state_in = ST_CORDIC;
         iter_in  = '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               iter_in = '0;
            end
            ST_CORDIC: begin
               iter_in = iter_ff + 1'b1;
               if (iter_ff == LAST_STEP) begin
                  state_in = ST_QMUL_A;
               end
            end
            ST_QMUL_A: state_in = ST_QMUL_B;
            ST_QMUL_B: state_in = ST_QSUM;
            ST_QSUM:   state_in = ST_MMUL;
            ST_MMUL:   state_in = ST_MSUM;
            ST_MSUM:   state_in = ST_IDLE;
            default:   state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
         qw_ff    <= $signed(eqvt_pkg::QUAT_BITS'(1) << eqvt_pkg::QUAT_FRAC);
         qx_ff    <= '0;
         qy_ff    <= '0;
         qz_ff    <= '0;
         for (int k = 0; k < 9; k++) begin
            mat_ff[k] <= ((k % 4) == 0) ?
               (eqvt_pkg::MAT_W'(1) << eqvt_pkg::MAT_FRAC) : '0;
         end
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         if (state_ff == ST_QSUM) begin
            qw_ff <= qw_in;
            qx_ff <= qx_in;
            qy_ff <= qy_in;
            qz_ff <= qz_in;
         end
         if (state_ff == ST_MSUM) begin
            mat_ff <= mat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         cx_ff[l] <= cx_in[l];
         cy_ff[l] <= cy_in[l];
         cz_ff[l] <= cz_in[l];
      end
      if (state_ff == ST_QMUL_A) begin
         a_ff <= a_in;
      end
      if (state_ff == ST_QMUL_B) begin
         b_ff <= b_in;
      end
      if (state_ff == ST_MMUL) begin
         m_ff <= m_in;
      end
   end

   assign busy   = start || (state_ff != ST_IDLE);
   assign matrix = mat_ff;

`ifndef SYNTHESIS
   a_start_enters_cordic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> (state_ff == ST_CORDIC && iter_ff == '0))
      else $error("setup did not enter CORDIC on start");
   a_cordic_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC && iter_ff == LAST_STEP && !start) |=> (state_ff == ST_QMUL_A))
      else $error("CORDIC did not end after the last step");
   a_matrix_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MSUM && !start) |=> (state_ff == ST_IDLE))
      else $error("setup did not return to idle after the matrix update");
`endif

endmodule

@@ rtl/euler_quat_vertex_transform_core.sv @@
// Vertex pipeline top level of the Euler-to-quaternion vertex transform core.
// Depends on eqvt_pkg and eqvt_rot_setup.
//
// Takes one vertex per cycle while req_stall is low (no rotation rebuild and
// no back-pressure from rsp_stall) through four register stages (multiply by
// matrix, row sum, scale, offset and saturate); the result is presented on the
// response port from the offset stage. Scale and offset writes apply at once.
// A write to pitch, yaw or roll rebuilds the rotation through a 24-step CORDIC
// and the quaternion and matrix multipliers, and req_stall stays high meanwhile.
module euler_quat_vertex_transform_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  eqvt_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output eqvt_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_wr_en,
   input  logic [eqvt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [eqvt_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   eqvt_pkg::angle_type                  angles_ff;
   logic [eqvt_pkg::SCALE_W-1:0]         scale_ff;
   logic signed [eqvt_pkg::OFFSET_W-1:0] ofs_ff [3];
   logic                                 start_ff, start_in;
   logic                                 setup_busy;
   eqvt_pkg::mat_type                    matrix;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   logic accept;

   logic signed [eqvt_pkg::VPROD_W-1:0] p1_ff [9];
   logic signed [eqvt_pkg::VPROD_W-1:0] p1_in [9];
   logic signed [eqvt_pkg::T_W-1:0]     t2_ff [3];
   logic signed [eqvt_pkg::T_W-1:0]     t2_in [3];
   logic signed [eqvt_pkg::SPROD_W-1:0] s3_ff [3];
   logic signed [eqvt_pkg::SPROD_W-1:0] s3_in [3];
   logic signed [eqvt_pkg::WORLD_W-1:0] w4_in [3];
   logic        [2:0]                   hit4;
   eqvt_pkg::rsp_payload_type           rsp_ff, rsp_in;
   logic signed [eqvt_pkg::VERTEX_W-1:0] vin [3];

   eqvt_rot_setup u_setup (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .angles (angles_ff),
      .busy   (setup_busy),
      .matrix (matrix)
   );

   always_comb begin
      start_in = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            eqvt_pkg::CSR_PITCH, eqvt_pkg::CSR_YAW, eqvt_pkg::CSR_ROLL: start_in = 1'b1;
            default: start_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angles_ff <= '0;
         scale_ff  <= eqvt_pkg::SCALE_W'(256);
         ofs_ff[0] <= '0;
         ofs_ff[1] <= '0;
         ofs_ff[2] <= '0;
         start_ff  <= 1'b0;
      end else begin
         start_ff <= start_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               eqvt_pkg::CSR_PITCH:    angles_ff.pitch <= csr_wr_data[eqvt_pkg::ANGLE_W-1:0];
               eqvt_pkg::CSR_YAW:      angles_ff.yaw   <= csr_wr_data[eqvt_pkg::ANGLE_W-1:0];
               eqvt_pkg::CSR_ROLL:     angles_ff.roll  <= csr_wr_data[eqvt_pkg::ANGLE_W-1:0];
               eqvt_pkg::CSR_SCALE:    scale_ff        <= csr_wr_data[eqvt_pkg::SCALE_W-1:0];
               eqvt_pkg::CSR_OFFSET_X: ofs_ff[0]       <= csr_wr_data[eqvt_pkg::OFFSET_W-1:0];
               eqvt_pkg::CSR_OFFSET_Y: ofs_ff[1]       <= csr_wr_data[eqvt_pkg::OFFSET_W-1:0];
               eqvt_pkg::CSR_OFFSET_Z: ofs_ff[2]       <= csr_wr_data[eqvt_pkg::OFFSET_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rdy4      = !v4_ff || !rsp_stall;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = setup_busy || !rdy1;
   assign accept    = req_valid && !req_stall;

   assign vin[0] = req_payload.vertex_x;
   assign vin[1] = req_payload.vertex_y;
   assign vin[2] = req_payload.vertex_z;

   always_comb begin
      logic signed [eqvt_pkg::MAT_W-1:0]  me;
      logic        [eqvt_pkg::VSUM_W-1:0] sum;
      logic        [eqvt_pkg::SPROD_W-1:0] sr;
      logic signed [eqvt_pkg::SRND_W-1:0] q;
      logic signed [eqvt_pkg::WSUM_W-1:0] w;
      logic [eqvt_pkg::WSUM_W-eqvt_pkg::WORLD_W:0] top;
      for (int k = 0; k < 9; k++) begin
         me       = $signed(matrix[k]);
         p1_in[k] = me * vin[k % 3];
      end
      for (int r = 0; r < 3; r++) begin
         sum = eqvt_pkg::VSUM_W'(p1_ff[3*r]) + eqvt_pkg::VSUM_W'(p1_ff[3*r+1])
             + eqvt_pkg::VSUM_W'(p1_ff[3*r+2])
             + (eqvt_pkg::VSUM_W'(1) << (eqvt_pkg::VRND_SHIFT - 1));
         t2_in[r] = $signed(sum[eqvt_pkg::VSUM_W-1:eqvt_pkg::VRND_SHIFT]);
         s3_in[r] = t2_ff[r] * $signed({1'b0, scale_ff});
         sr = s3_ff[r] + (eqvt_pkg::SPROD_W'(1) << (eqvt_pkg::SRND_SHIFT - 1));
         q  = $signed(sr[eqvt_pkg::SPROD_W-1:eqvt_pkg::SRND_SHIFT]);
         w  = eqvt_pkg::WSUM_W'(q) + eqvt_pkg::WSUM_W'(ofs_ff[r]);
         top = w[eqvt_pkg::WSUM_W-1:eqvt_pkg::WORLD_W-1];
         if ((top == '0) || (top == '1)) begin
            w4_in[r] = w[eqvt_pkg::WORLD_W-1:0];
            hit4[r]  = 1'b0;
         end else begin
            w4_in[r] = w[eqvt_pkg::WSUM_W-1] ? $signed({1'b1, {(eqvt_pkg::WORLD_W-1){1'b0}}})
                                             : $signed({1'b0, {(eqvt_pkg::WORLD_W-1){1'b1}}});
            hit4[r]  = 1'b1;
         end
      end
      rsp_in.world_x = w4_in[0];
      rsp_in.world_y = w4_in[1];
      rsp_in.world_z = w4_in[2];
      rsp_in.clipped = |hit4;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= accept;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) p1_ff  <= p1_in;
      if (rdy2) t2_ff  <= t2_in;
      if (rdy3) s3_ff  <= s3_in;
      if (rdy4) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = v4_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !setup_busy)
      else $error("transaction accepted during rotation rebuild");
   a_angle_write_stalls: assert property (@(posedge clock) disable iff (reset)
      start_in |=> req_stall)
      else $error("input not stalled after angle write");
   a_stage_to_out: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && rdy4) |=> v4_ff)
      else $error("result lost between scale stage and output");
`endif

endmodule
